/* design/lvlmb_pkg.sv */
package lvlmb_pkg;

    // Width of the configuration register index.
    localparam int CFG_INDEX_BITS = 3;

    // Item commands.
    typedef enum logic {
        CMD_SAMPLE    = 1'b0,
        CMD_CLEAR_MAX = 1'b1
    } cmd_t;

    // Meter display modes. The fourth code is shown as peak.
    typedef enum logic [1:0] {
        MODE_PEAK     = 2'd0,
        MODE_RMS_PEAK = 2'd1,
        MODE_VU       = 2'd2
    } meter_mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ATTACK_COEF    = 3'd0,
        CFG_RELEASE_COEF   = 3'd1,
        CFG_BALANCE_ENABLE = 3'd2,
        CFG_BALANCE_LEVEL  = 3'd3,
        CFG_METER_MODE     = 3'd4
    } cfg_index_t;

    // Mode controls handed from the register file to the datapath.
    typedef struct packed {
        logic        balance_enable;
        meter_mode_t meter_mode;
    } mode_cfg_t;

endpackage

/* design/lvlmb_item_if.sv */
interface lvlmb_item_if
    import lvlmb_pkg::*;
#(
    parameter int LEVEL_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    cmd_t                         cmd;
    logic signed [LEVEL_BITS-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

/* design/lvlmb_result_if.sv */
interface lvlmb_result_if #(
    parameter int LEVEL_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [LEVEL_BITS-1:0] bar_level;
    logic signed [LEVEL_BITS-1:0] peak_marker;
    logic signed [LEVEL_BITS-1:0] max_hold;

    modport source (output valid, output bar_level, output peak_marker, output max_hold,
                    input ready);
    modport sink   (input valid, input bar_level, input peak_marker, input max_hold,
                    output ready);
endinterface

/* design/lvlmb_cfg_if.sv */
interface lvlmb_cfg_if
    import lvlmb_pkg::*;
#(
    parameter int DATA_BITS = 24
) ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/level_meter_ballistics_unit.sv */
// Channel  Direction  Transaction payload
// -------  ---------  ----------------------------------------------
// cfg      in         index (register number), data (register value)
// item     in         cmd (sample or clear max-hold), sample (Q8.16)
// result   out        bar_level, peak_marker, max_hold (Q8.16)
//
// One transaction on item yields one transaction on result. A new item is
// taken every cycle while result is not held; the limit is the feedback
// through the coefficient multipliers into the level registers.
// Reset clears the stored levels and loads the default coefficients.
// A held result stalls the input register, which stalls item in turn.
module level_meter_ballistics_unit
    import lvlmb_pkg::*;
#(
    parameter int LEVEL_BITS     = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    lvlmb_cfg_if.sink       cfg,
    lvlmb_item_if.sink      item,
    lvlmb_result_if.source  result
);
    localparam int COEF_BITS = COEF_FRAC_BITS + 1;

    // Configuration registers.
    logic [COEF_BITS-1:0]         attack_coef;
    logic [COEF_BITS-1:0]         release_coef;
    logic signed [LEVEL_BITS-1:0] balance_level;
    mode_cfg_t                    mode_cfg;

    // Input register stage.
    logic                         in_valid_reg;
    cmd_t                         cmd_reg;
    logic signed [LEVEL_BITS-1:0] sample_reg;

    // Stored meter levels.
    logic signed [LEVEL_BITS-1:0] peak_reg;
    logic signed [LEVEL_BITS-1:0] rms_reg;
    logic signed [LEVEL_BITS-1:0] hold_reg;
    logic signed [LEVEL_BITS-1:0] peak_next;
    logic signed [LEVEL_BITS-1:0] rms_next;
    logic signed [LEVEL_BITS-1:0] hold_next;
    logic signed [LEVEL_BITS-1:0] bar_next;

    // Result register stage.
    logic                         out_valid_reg;
    logic signed [LEVEL_BITS-1:0] bar_reg;
    logic signed [LEVEL_BITS-1:0] peak_out_reg;
    logic signed [LEVEL_BITS-1:0] hold_out_reg;

    logic                         item_take;
    logic                         advance;

    lvlmb_cfg_regs #(
        .LEVEL_BITS     (LEVEL_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cfg_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .attack_coef   (attack_coef),
        .release_coef  (release_coef),
        .balance_level (balance_level),
        .mode_cfg      (mode_cfg)
    );

    // The held item moves on whenever the result register is empty or
    // is being emptied in this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign item_take  = item.valid && item.ready;

    lvlmb_update #(
        .LEVEL_BITS     (LEVEL_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_update (
        .cmd           (cmd_reg),
        .sample        (sample_reg),
        .peak_level    (peak_reg),
        .rms_level     (rms_reg),
        .hold_level    (hold_reg),
        .attack_coef   (attack_coef),
        .release_coef  (release_coef),
        .balance_level (balance_level),
        .mode_cfg      (mode_cfg),
        .peak_next     (peak_next),
        .rms_next      (rms_next),
        .hold_next     (hold_next),
        .bar_next      (bar_next)
    );

    // Control and level state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
            rms_reg       <= '0;
            hold_reg      <= '0;
        end
        else
        begin
            if (item_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                peak_reg      <= peak_next;
                rms_reg       <= rms_next;
                hold_reg      <= hold_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            cmd_reg    <= item.cmd;
            sample_reg <= item.sample;
        end
        if (advance)
        begin
            bar_reg      <= bar_next;
            peak_out_reg <= peak_next;
            hold_out_reg <= hold_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.bar_level   = bar_reg;
    assign result.peak_marker = peak_out_reg;
    assign result.max_hold    = hold_out_reg;
endmodule

/* design/lvlmb_cfg_regs.sv */
module lvlmb_cfg_regs
    import lvlmb_pkg::*;
#(
    parameter int LEVEL_BITS     = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lvlmb_cfg_if.sink                    cfg,
    output logic [COEF_FRAC_BITS:0]      attack_coef,
    output logic [COEF_FRAC_BITS:0]      release_coef,
    output logic signed [LEVEL_BITS-1:0] balance_level,
    output mode_cfg_t                    mode_cfg
);
    localparam int COEF_BITS = COEF_FRAC_BITS + 1;
    // Defaults of 0.1 and 0.25 in the coefficient format.
    localparam logic [COEF_BITS-1:0] ATTACK_RESET  = COEF_BITS'(((2 ** COEF_FRAC_BITS) + 5) / 10);
    localparam logic [COEF_BITS-1:0] RELEASE_RESET = COEF_BITS'((2 ** COEF_FRAC_BITS) / 4);

    logic [COEF_BITS-1:0]         attack_reg;
    logic [COEF_BITS-1:0]         release_reg;
    logic signed [LEVEL_BITS-1:0] balance_level_reg;
    mode_cfg_t                    mode_reg;
    logic                         wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg              <= ATTACK_RESET;
            release_reg             <= RELEASE_RESET;
            balance_level_reg       <= '0;
            mode_reg.balance_enable <= 1'b0;
            mode_reg.meter_mode     <= MODE_PEAK;
        end
        else if (wr_en)
        begin
            unique case (cfg.index)
                CFG_ATTACK_COEF:    attack_reg  <= cfg.data[COEF_BITS-1:0];
                CFG_RELEASE_COEF:   release_reg <= cfg.data[COEF_BITS-1:0];
                CFG_BALANCE_ENABLE: mode_reg.balance_enable <= cfg.data[0];
                CFG_BALANCE_LEVEL:  balance_level_reg <= $signed(cfg.data[LEVEL_BITS-1:0]);
                CFG_METER_MODE:     mode_reg.meter_mode <= meter_mode_t'(cfg.data[1:0]);
                default:            ;
            endcase
        end
    end

    assign attack_coef   = attack_reg;
    assign release_coef  = release_reg;
    assign balance_level = balance_level_reg;
    assign mode_cfg      = mode_reg;
endmodule

/* design/lvlmb_approach.sv */
module lvlmb_approach #(
    parameter int LEVEL_BITS     = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic signed [LEVEL_BITS-1:0] level,
    input  logic signed [LEVEL_BITS-1:0] target,
    input  logic [COEF_FRAC_BITS:0]      coef,
    output logic signed [LEVEL_BITS-1:0] result
);
    localparam int COEF_BITS = COEF_FRAC_BITS + 1;
    localparam int PROD_BITS = COEF_BITS + 1 + LEVEL_BITS + 1;
    localparam logic signed [PROD_BITS-1:0] SAT_HI =
        PROD_BITS'((64'sd1 <<< (LEVEL_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_BITS-1:0] SAT_LO = -SAT_HI - PROD_BITS'(1);

    logic signed [COEF_BITS:0]      coef_s;
    logic signed [LEVEL_BITS:0]     diff;
    logic signed [PROD_BITS-1:0]    prod;
    logic signed [PROD_BITS-1:0]    step;
    logic signed [PROD_BITS-1:0]    sum;

    // The arithmetic shift floors the scaled step toward minus infinity.
    always_comb
    begin
        coef_s = $signed({1'b0, coef});
        diff   = (LEVEL_BITS + 1)'(target) - (LEVEL_BITS + 1)'(level);
        prod   = coef_s * diff;
        step   = prod >>> COEF_FRAC_BITS;
        sum    = PROD_BITS'(level) + step;
        if (sum > SAT_HI)
            result = SAT_HI[LEVEL_BITS-1:0];
        else if (sum < SAT_LO)
            result = SAT_LO[LEVEL_BITS-1:0];
        else
            result = sum[LEVEL_BITS-1:0];
    end
endmodule

/* design/lvlmb_update.sv */
module lvlmb_update
    import lvlmb_pkg::*;
#(
    parameter int LEVEL_BITS     = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  cmd_t                         cmd,
    input  logic signed [LEVEL_BITS-1:0] sample,
    input  logic signed [LEVEL_BITS-1:0] peak_level,
    input  logic signed [LEVEL_BITS-1:0] rms_level,
    input  logic signed [LEVEL_BITS-1:0] hold_level,
    input  logic [COEF_FRAC_BITS:0]      attack_coef,
    input  logic [COEF_FRAC_BITS:0]      release_coef,
    input  logic signed [LEVEL_BITS-1:0] balance_level,
    input  mode_cfg_t                    mode_cfg,
    output logic signed [LEVEL_BITS-1:0] peak_next,
    output logic signed [LEVEL_BITS-1:0] rms_next,
    output logic signed [LEVEL_BITS-1:0] hold_next,
    output logic signed [LEVEL_BITS-1:0] bar_next
);
    localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};
    localparam logic signed [LEVEL_BITS-1:0] LEVEL_MAX = {1'b0, {(LEVEL_BITS-1){1'b1}}};

    logic signed [LEVEL_BITS-1:0] abs_sample;
    logic signed [LEVEL_BITS-1:0] peak_decay;
    logic signed [LEVEL_BITS-1:0] rms_step;
    logic [COEF_FRAC_BITS:0]      rms_coef;
    logic                         jump;
    logic signed [LEVEL_BITS-1:0] peak_upd;
    logic signed [LEVEL_BITS-1:0] rms_upd;

    // The most negative sample has no positive twin and saturates.
    always_comb
    begin
        if (sample == LEVEL_MIN)
            abs_sample = LEVEL_MAX;
        else if (sample < 0)
            abs_sample = -sample;
        else
            abs_sample = sample;
    end

    assign rms_coef = (abs_sample > rms_level) ? attack_coef : release_coef;

    lvlmb_approach #(
        .LEVEL_BITS     (LEVEL_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_peak_step (
        .level  (peak_level),
        .target (sample),
        .coef   (release_coef),
        .result (peak_decay)
    );

    lvlmb_approach #(
        .LEVEL_BITS     (LEVEL_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rms_step (
        .level  (rms_level),
        .target (abs_sample),
        .coef   (rms_coef),
        .result (rms_step)
    );

    always_comb
    begin
        // In balance mode the peak jumps outward, away from the centre level.
        if (mode_cfg.balance_enable)
        begin
            if (sample > balance_level)
                jump = (peak_level <= sample);
            else
                jump = (peak_level > sample);
        end
        else
        begin
            jump = (peak_level < sample);
        end

        peak_upd = jump ? sample : peak_decay;
        rms_upd  = (rms_step < 0) ? '0 : rms_step;

        if (cmd == CMD_CLEAR_MAX)
        begin
            peak_next = peak_level;
            rms_next  = rms_level;
            hold_next = '0;
        end
        else
        begin
            peak_next = peak_upd;
            rms_next  = rms_upd;
            hold_next = (peak_upd > hold_level) ? peak_upd : hold_level;
        end

        case (mode_cfg.meter_mode)
            MODE_RMS_PEAK: bar_next = rms_next;
            default:       bar_next = peak_next;
        endcase
    end
endmodule
